// ===== rtl/btffa_pkg.sv =====
// ----------------------------------------------------------------------------
// btffa_pkg
// Shared types and constants of the first-fit block table allocator.
// ----------------------------------------------------------------------------
package btffa_pkg;

    // Built table geometry.
    localparam int TABLE_BLOCKS = 1024;
    localparam int BLOCK_BYTES  = 4096;

    localparam int IDX_W     = $clog2(TABLE_BLOCKS);
    localparam int CNT_W     = $clog2(TABLE_BLOCKS + 1);
    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int WIDE_W    = 33;
    localparam int NEED_W    = WIDE_W - BLK_SHIFT;
    localparam int OFF_W     = 32 - BLK_SHIFT;

    // Configuration registers.
    localparam int BIU_W = 11;
    localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_HEAP_BASE     = 1'b0;
    localparam cfg_idx_t REG_BLOCKS_IN_USE = 1'b1;

    // Table entry encoding.
    typedef logic [1:0] entry_t;
    localparam entry_t ENT_FREE  = 2'b00;
    localparam entry_t ENT_TAKEN = 2'b01;
    localparam entry_t ENT_NEXT  = 2'b10;

    // Request type codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Status codes.
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [NEED_W-1:0] need_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] request_bytes;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic        status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_A_RD,
        ST_A_EVAL,
        ST_MARK,
        ST_F_RD,
        ST_F_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_ALLOC_OK,
        RES_FREE_OK,
        RES_ERR
    } res_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     load;
        logic     scan_init;
        logic     scan_eval;
        logic     mark_step;
        logic     free_init;
        logic     free_clr;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic size_bad;
        logic free_bad;
        logic run_hit;
        logic scan_last;
        logic mark_last;
        logic walk_stop;
    } dp_stat_t;

endpackage

// ===== rtl/btffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// btffa_ctrl
// Sequencer for table clearing, first-fit scan, run marking and chain free.
// ----------------------------------------------------------------------------
module btffa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  btffa_pkg::dp_stat_t stat,
    output btffa_pkg::ctl_cmd_t cmd,
    output logic                busy,
    output logic                done
);

    btffa_pkg::state_t state_reg;
    btffa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btffa_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btffa_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = btffa_pkg::ST_IDLE;
                end
            end
            btffa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = btffa_pkg::ST_CHECK;
                end
            end
            btffa_pkg::ST_CHECK:
            begin
                if (stat.is_free)
                begin
                    state_next = stat.free_bad ? btffa_pkg::ST_DONE : btffa_pkg::ST_F_RD;
                end
                else
                begin
                    state_next = stat.size_bad ? btffa_pkg::ST_DONE : btffa_pkg::ST_A_RD;
                end
            end
            btffa_pkg::ST_A_RD:
            begin
                state_next = btffa_pkg::ST_A_EVAL;
            end
            btffa_pkg::ST_A_EVAL:
            begin
                if (stat.run_hit)
                begin
                    state_next = btffa_pkg::ST_MARK;
                end
                else if (stat.scan_last)
                begin
                    state_next = btffa_pkg::ST_DONE;
                end
                else
                begin
                    state_next = btffa_pkg::ST_A_RD;
                end
            end
            btffa_pkg::ST_MARK:
            begin
                if (stat.mark_last)
                begin
                    state_next = btffa_pkg::ST_DONE;
                end
            end
            btffa_pkg::ST_F_RD:
            begin
                state_next = btffa_pkg::ST_F_EVAL;
            end
            btffa_pkg::ST_F_EVAL:
            begin
                state_next = stat.walk_stop ? btffa_pkg::ST_DONE : btffa_pkg::ST_F_RD;
            end
            btffa_pkg::ST_DONE:
            begin
                state_next = btffa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btffa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.res_sel = btffa_pkg::RES_NONE;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            btffa_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            btffa_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            btffa_pkg::ST_CHECK:
            begin
                if (stat.is_free)
                begin
                    if (stat.free_bad)
                    begin
                        cmd.res_sel = btffa_pkg::RES_FREE_OK;
                    end
                    else
                    begin
                        cmd.free_init = 1'b1;
                    end
                end
                else
                begin
                    if (stat.size_bad)
                    begin
                        cmd.res_sel = btffa_pkg::RES_ERR;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                    end
                end
            end
            btffa_pkg::ST_A_RD:
            begin
                cmd = '0;
            end
            btffa_pkg::ST_A_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                if (!stat.run_hit && stat.scan_last)
                begin
                    cmd.res_sel = btffa_pkg::RES_ERR;
                end
            end
            btffa_pkg::ST_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last)
                begin
                    cmd.res_sel = btffa_pkg::RES_ALLOC_OK;
                end
            end
            btffa_pkg::ST_F_RD:
            begin
                cmd = '0;
            end
            btffa_pkg::ST_F_EVAL:
            begin
                cmd.free_clr = 1'b1;
                if (stat.walk_stop)
                begin
                    cmd.res_sel = btffa_pkg::RES_FREE_OK;
                end
            end
            btffa_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/btffa_dp.sv =====
// ----------------------------------------------------------------------------
// btffa_dp
// Block table memory, configuration registers, scan counters and result.
// ----------------------------------------------------------------------------
module btffa_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  btffa_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]         cfg_data,
    input  btffa_pkg::req_t     req,
    input  btffa_pkg::ctl_cmd_t cmd,
    output btffa_pkg::dp_stat_t stat,
    output btffa_pkg::rsp_t     rsp
);

    // Block table: one entry per heap block, no reset (cleared by a sweep).
    btffa_pkg::entry_t mem [btffa_pkg::TABLE_BLOCKS];

    logic [31:0]                 heap_base_reg;
    logic [btffa_pkg::BIU_W-1:0] biu_reg;
    btffa_pkg::cnt_t             idx_reg;
    btffa_pkg::cnt_t             run_reg;
    btffa_pkg::idx_t             start_reg;
    logic                        is_free_reg;
    btffa_pkg::need_t            need_reg;
    logic                        free_lt_reg;
    btffa_pkg::off_t             free_idx_reg;
    btffa_pkg::entry_t           rd_data_reg;
    btffa_pkg::rsp_t             rsp_reg;

    btffa_pkg::wide_t   need_sum;
    btffa_pkg::wide_t   free_diff;
    btffa_pkg::cnt_t    limit;
    btffa_pkg::cnt_t    idx_inc;
    btffa_pkg::cnt_t    run_inc;
    btffa_pkg::idx_t    start_eff;
    logic               ent_free;
    logic               mem_we;
    btffa_pkg::entry_t  mem_wdata;
    logic [31:0]        alloc_addr;

    assign need_sum  = {1'b0, req.request_bytes}
                     + btffa_pkg::wide_t'(btffa_pkg::BLOCK_BYTES - 1);
    assign free_diff = {1'b0, req.free_address} - {1'b0, heap_base_reg};

    // Managed count is the configured count clamped to the built depth.
    always_comb
    begin
        if (32'(biu_reg) >= 32'(btffa_pkg::TABLE_BLOCKS))
        begin
            limit = btffa_pkg::cnt_t'(btffa_pkg::TABLE_BLOCKS);
        end
        else
        begin
            limit = btffa_pkg::cnt_t'(biu_reg);
        end
    end

    assign idx_inc   = idx_reg + btffa_pkg::cnt_t'(1);
    assign run_inc   = run_reg + btffa_pkg::cnt_t'(1);
    assign start_eff = (run_reg == '0) ? idx_reg[btffa_pkg::IDX_W-1:0] : start_reg;
    assign ent_free  = (rd_data_reg & btffa_pkg::ENT_TAKEN) == btffa_pkg::ENT_FREE;
    assign alloc_addr = heap_base_reg + (32'(start_reg) << btffa_pkg::BLK_SHIFT);

    always_comb
    begin
        stat.clear_last = idx_reg == btffa_pkg::cnt_t'(btffa_pkg::TABLE_BLOCKS - 1);
        stat.is_free    = is_free_reg;
        stat.size_bad   = (need_reg == '0)
                        || (btffa_pkg::wide_t'(need_reg) > btffa_pkg::wide_t'(limit));
        stat.free_bad   = free_lt_reg
                        || (btffa_pkg::wide_t'(free_idx_reg) >= btffa_pkg::wide_t'(limit));
        stat.run_hit    = ent_free
                        && (btffa_pkg::wide_t'(run_inc) == btffa_pkg::wide_t'(need_reg));
        stat.scan_last  = idx_inc == limit;
        stat.mark_last  = run_reg == btffa_pkg::cnt_t'(1);
        stat.walk_stop  = ((rd_data_reg & btffa_pkg::ENT_NEXT) == btffa_pkg::ENT_FREE)
                        || (idx_inc >= limit);
    end

    // Single write port shared by the clearing sweep, marking and freeing.
    always_comb
    begin
        mem_we    = cmd.clr_step || cmd.mark_step || cmd.free_clr;
        mem_wdata = btffa_pkg::ENT_FREE;
        if (cmd.mark_step)
        begin
            mem_wdata = (run_reg != btffa_pkg::cnt_t'(1))
                      ? (btffa_pkg::ENT_TAKEN | btffa_pkg::ENT_NEXT)
                      : btffa_pkg::ENT_TAKEN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg[btffa_pkg::IDX_W-1:0]] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg[btffa_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            biu_reg       <= btffa_pkg::BIU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btffa_pkg::REG_HEAP_BASE:
                begin
                    heap_base_reg <= cfg_data;
                end
                btffa_pkg::REG_BLOCKS_IN_USE:
                begin
                    biu_reg <= cfg_data[btffa_pkg::BIU_W-1:0];
                end
                default:
                begin
                    heap_base_reg <= heap_base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            run_reg   <= '0;
            start_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                idx_reg <= idx_inc;
            end
            else if (cmd.scan_init)
            begin
                idx_reg <= '0;
                run_reg <= '0;
            end
            else if (cmd.scan_eval)
            begin
                if (stat.run_hit)
                begin
                    // Rewind to the head of the run and count it down while marking.
                    idx_reg   <= btffa_pkg::cnt_t'(start_eff);
                    start_reg <= start_eff;
                    run_reg   <= run_inc;
                end
                else if (ent_free)
                begin
                    start_reg <= start_eff;
                    run_reg   <= run_inc;
                    idx_reg   <= idx_inc;
                end
                else
                begin
                    run_reg <= '0;
                    idx_reg <= idx_inc;
                end
            end
            else if (cmd.mark_step)
            begin
                idx_reg <= idx_inc;
                run_reg <= run_reg - btffa_pkg::cnt_t'(1);
            end
            else if (cmd.free_init)
            begin
                idx_reg <= btffa_pkg::cnt_t'(free_idx_reg);
            end
            else if (cmd.free_clr)
            begin
                idx_reg <= idx_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_free_reg  <= req.req_type == btffa_pkg::REQ_FREE;
            need_reg     <= need_sum[btffa_pkg::WIDE_W-1:btffa_pkg::BLK_SHIFT];
            free_lt_reg  <= free_diff[btffa_pkg::WIDE_W-1];
            free_idx_reg <= free_diff[31:btffa_pkg::BLK_SHIFT];
        end
        case (cmd.res_sel)
            btffa_pkg::RES_ALLOC_OK:
            begin
                rsp_reg.result_address <= alloc_addr;
                rsp_reg.status         <= btffa_pkg::STAT_OK;
            end
            btffa_pkg::RES_FREE_OK:
            begin
                rsp_reg.result_address <= '0;
                rsp_reg.status         <= btffa_pkg::STAT_OK;
            end
            btffa_pkg::RES_ERR:
            begin
                rsp_reg.result_address <= '0;
                rsp_reg.status         <= btffa_pkg::STAT_ERR;
            end
            default:
            begin
                rsp_reg <= rsp_reg;
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/block_table_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// block_table_first_fit_allocator_unit
// First-fit heap allocator over a table of fixed-size blocks.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// transaction follows, shown for a single cycle with done high, and the
// receiver must capture it then because it cannot be held off. After reset
// the block sweeps its 1024-entry table to free, one entry per cycle, and
// holds busy high until the sweep ends; configuration writes are taken at
// any time but must only be issued while busy is low. An allocate scans
// the table up to the end of the first fitting run and then marks each
// block of that run; a free clears the entries of the chain it walks. The
// table memory has one read and one write port and a registered read, and
// is visited one entry at a time. Sizes of zero and requests that find no
// long enough run report status 1 with address zero; frees outside the
// managed table are ignored and report success.
// ----------------------------------------------------------------------------
module block_table_first_fit_allocator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  btffa_pkg::req_t     req,
    output logic                done,
    output btffa_pkg::rsp_t     rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  btffa_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]         cfg_data
);

    btffa_pkg::ctl_cmd_t cmd;
    btffa_pkg::dp_stat_t stat;

    // Configuration registers accept a write transaction in every cycle.
    assign cfg_ready = 1'b1;

    btffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    btffa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

    // An accepted request keeps the block busy until its result is delivered.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // The result strobe lasts exactly one cycle and returns the block to idle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // A failed allocation never reports a nonzero address.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status) |-> (rsp.result_address == 32'd0))
        else $error("error result carries an address");

    // A result is only shown while a request is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

endmodule
